@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/tlip_pkg.sv @@
// Package for the two-list index partition unit: codes, states and shared structs.
package tlip_pkg;

    localparam int TLIP_MAX_ITEMS    = 256;
    localparam int TLIP_SIZE_DEFAULT = 256;

    typedef enum logic [1:0] {
        OP_SWAP  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } tlip_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOK,
        ST_MOVE,
        ST_LINK,
        ST_RESULT
    } tlip_state_t;

    // RAM strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic next_we;
        logic prev_we;
    } ram_ctl_t;

    // Result status handed to the output register
    typedef struct packed {
        logic valid;
        logic ok;
        logic in_set;
    } res_stat_t;

endpackage

@@ design/tlip_ram.sv @@
// Generic single-port-write, registered-read RAM.
module tlip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/tlip_ctrl.sv @@
// Sequencer and list registers: drives the link RAMs one update per cycle, none in IDLE or RESULT.
module tlip_ctrl
    import tlip_pkg::*;
#(
    parameter int MAX_ITEMS = TLIP_MAX_ITEMS
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]    size_in_use,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]    item_index,
    input  logic                              res_ready,
    output res_stat_t                         res_stat,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    res_next,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    res_prev,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    list_in_count,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    list_out_count,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    list_first_in,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    list_last_in,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    list_first_out,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    list_last_out,
    output ram_ctl_t                          ram_ctl,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    raddr,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    waddr_next,
    output logic [$clog2(MAX_ITEMS+1):0]      wdata_next,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    waddr_prev,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    wdata_prev,
    input  logic [$clog2(MAX_ITEMS+1):0]      rdata_next,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]    rdata_prev
);

    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int SIZE_RST = (TLIP_SIZE_DEFAULT > MAX_ITEMS) ? MAX_ITEMS : TLIP_SIZE_DEFAULT;
    localparam logic [IW-1:0] MAX_IDX  = IW'(MAX_ITEMS);
    localparam logic [IW-1:0] SIZE_RV  = IW'(SIZE_RST);
    localparam logic [IW-1:0] ONE      = IW'(1);

    tlip_state_t    state_reg, state_next;
    logic [1:0]     op_reg, op_next;
    logic [IW-1:0]  cur_reg, cur_next;
    logic [IW-1:0]  nx_reg, nx_next;
    logic [IW-1:0]  pv_reg, pv_next;
    logic           inb_reg, inb_next;
    logic [IW-1:0]  size_reg, size_next;
    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]  in_head_reg, in_head_next;
    logic [IW-1:0]  in_tail_reg, in_tail_next;
    logic [IW-1:0]  out_head_reg, out_head_next;
    logic [IW-1:0]  out_tail_reg, out_tail_next;
    logic [IW-1:0]  in_total_reg, in_total_next;
    logic [IW-1:0]  out_total_reg, out_total_next;
    logic           ok_reg, ok_next;
    logic           inset_reg, inset_next;
    logic [IW-1:0]  rnext_reg, rnext_next;
    logic [IW-1:0]  rprev_reg, rprev_next;

    logic           idx_valid;
    logic           op_is_clear;
    logic           op_is_lookup;
    logic [IW-1:0]  dst_tail;
    logic [IW-1:0]  look_nx;
    logic           look_inb;
    logic [IW-1:0]  cfg_size;

    assign idx_valid    = (item_index != '0) && (item_index <= size_reg);
    assign op_is_clear  = (op == OP_CLEAR);
    assign op_is_lookup = (op == OP_SWAP) || (op == OP_READ);
    // the list the item is moving to
    assign dst_tail     = inb_reg ? out_tail_reg : in_tail_reg;
    assign look_nx      = rdata_next[IW-1:0];
    assign look_inb     = rdata_next[IW];
    assign cfg_size     = (size_in_use == '0) ? ONE :
                          (size_in_use > MAX_IDX) ? MAX_IDX : size_in_use;

    assign res_next       = rnext_reg;
    assign res_prev       = rprev_reg;
    assign list_in_count  = in_total_reg;
    assign list_out_count = out_total_reg;
    assign list_first_in  = in_head_reg;
    assign list_last_in   = in_tail_reg;
    assign list_first_out = out_head_reg;
    assign list_last_out  = out_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            size_reg      <= SIZE_RV;
            cnt_reg       <= ONE;
            in_head_reg   <= '0;
            in_tail_reg   <= '0;
            out_head_reg  <= ONE;
            out_tail_reg  <= SIZE_RV;
            in_total_reg  <= '0;
            out_total_reg <= SIZE_RV;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            cnt_reg       <= cnt_next;
            in_head_reg   <= in_head_next;
            in_tail_reg   <= in_tail_next;
            out_head_reg  <= out_head_next;
            out_tail_reg  <= out_tail_next;
            in_total_reg  <= in_total_next;
            out_total_reg <= out_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cur_reg   <= cur_next;
        nx_reg    <= nx_next;
        pv_reg    <= pv_next;
        inb_reg   <= inb_next;
        ok_reg    <= ok_next;
        inset_reg <= inset_next;
        rnext_reg <= rnext_next;
        rprev_reg <= rprev_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        pv_next        = pv_reg;
        inb_next       = inb_reg;
        size_next      = size_reg;
        cnt_next       = cnt_reg;
        in_head_next   = in_head_reg;
        in_tail_next   = in_tail_reg;
        out_head_next  = out_head_reg;
        out_tail_next  = out_tail_reg;
        in_total_next  = in_total_reg;
        out_total_next = out_total_reg;
        ok_next        = ok_reg;
        inset_next     = inset_reg;
        rnext_next     = rnext_reg;
        rprev_next     = rprev_reg;
        ram_ctl        = '0;
        raddr          = cur_reg;
        waddr_next     = cur_reg;
        wdata_next     = '0;
        waddr_prev     = cur_reg;
        wdata_prev     = '0;
        res_stat       = '0;
        in_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_INIT:
            begin
                // lay out the chain 1..size in the out-list, one entry a cycle
                ram_ctl.next_we = 1'b1;
                ram_ctl.prev_we = 1'b1;
                waddr_next      = cnt_reg;
                waddr_prev      = cnt_reg;
                wdata_next      = {1'b0, (cnt_reg == size_reg) ? {IW{1'b0}} : cnt_reg + ONE};
                wdata_prev      = cnt_reg - ONE;
                cnt_next        = cnt_reg + ONE;
                if (cnt_reg == size_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                raddr = op_is_clear ? in_head_reg : item_index;
                if (in_valid)
                begin
                    ram_ctl.rd_en = (op_is_clear && (in_head_reg != '0)) ||
                                    (op_is_lookup && idx_valid);
                    op_next    = op;
                    cur_next   = raddr;
                    ok_next    = op_is_clear || (op_is_lookup && idx_valid);
                    inset_next = 1'b0;
                    rnext_next = '0;
                    rprev_next = '0;
                    state_next = ram_ctl.rd_en ? ST_LOOK : ST_RESULT;
                end
            end
            ST_LOOK:
            begin
                nx_next  = look_nx;
                pv_next  = rdata_prev;
                inb_next = look_inb;
                if (op_reg == OP_READ)
                begin
                    inset_next = look_inb;
                    rnext_next = look_nx;
                    rprev_next = rdata_prev;
                    state_next = ST_RESULT;
                end
                else
                begin
                    // unlink: predecessor skips forward, successor skips back
                    ram_ctl.next_we = (rdata_prev != '0);
                    waddr_next      = rdata_prev;
                    wdata_next      = {look_inb, look_nx};
                    ram_ctl.prev_we = (look_nx != '0);
                    waddr_prev      = look_nx;
                    wdata_prev      = rdata_prev;
                    state_next      = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                ram_ctl.next_we = 1'b1;
                ram_ctl.prev_we = 1'b1;
                wdata_next      = {~inb_reg, {IW{1'b0}}};
                wdata_prev      = dst_tail;
                state_next      = ST_LINK;
            end
            ST_LINK:
            begin
                ram_ctl.next_we = (dst_tail != '0);
                waddr_next      = dst_tail;
                wdata_next      = {~inb_reg, cur_reg};
                if (inb_reg)
                begin
                    if (nx_reg == '0)
                    begin
                        in_tail_next = pv_reg;
                    end
                    if (pv_reg == '0)
                    begin
                        in_head_next = nx_reg;
                    end
                    if (out_tail_reg == '0)
                    begin
                        out_head_next = cur_reg;
                    end
                    out_tail_next  = cur_reg;
                    in_total_next  = in_total_reg - ONE;
                    out_total_next = out_total_reg + ONE;
                end
                else
                begin
                    if (nx_reg == '0)
                    begin
                        out_tail_next = pv_reg;
                    end
                    if (pv_reg == '0)
                    begin
                        out_head_next = nx_reg;
                    end
                    if (in_tail_reg == '0)
                    begin
                        in_head_next = cur_reg;
                    end
                    in_tail_next   = cur_reg;
                    in_total_next  = in_total_reg + ONE;
                    out_total_next = out_total_reg - ONE;
                end
                if (op_reg == OP_SWAP)
                begin
                    inset_next = ~inb_reg;
                    rnext_next = '0;
                    rprev_next = dst_tail;
                    state_next = ST_RESULT;
                end
                else if (nx_reg != '0)
                begin
                    // clear walks the in-list from its head
                    raddr         = nx_reg;
                    ram_ctl.rd_en = 1'b1;
                    cur_next      = nx_reg;
                    state_next    = ST_LOOK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                res_stat.valid  = 1'b1;
                res_stat.ok     = ok_reg;
                res_stat.in_set = inset_reg;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                cnt_next   = ONE;
            end
        endcase

        if (cfg_we)
        begin
            size_next      = cfg_size;
            cnt_next       = ONE;
            in_head_next   = '0;
            in_tail_next   = '0;
            out_head_next  = ONE;
            out_tail_next  = cfg_size;
            in_total_next  = '0;
            out_total_next = cfg_size;
            state_next     = ST_INIT;
        end
    end

endmodule

@@ design/tlip_top_dummy.sv @@
// (unused)

@@ design/two_list_index_partition_unit.sv @@
// Top level of the two-list index partition unit: link RAMs, sequencer, result register.
// Swap: IDLE, LOOK, MOVE, LINK, then RESULT loads the output register; next request in IDLE.
// Read: IDLE, LOOK, RESULT; clear runs LOOK, MOVE, LINK for each in-list member, then RESULT.
// Requests run one at a time; a swap makes up to three writes on the single next-RAM write port.
// Reset or a size write starts an init pass that lays out the out-list chain; no request is taken then.
module two_list_index_partition_unit
    import tlip_pkg::*;
#(
    parameter int MAX_ITEMS = TLIP_MAX_ITEMS
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] size_in_use,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] item_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           index_ok,
    output logic                           in_set,
    output logic [$clog2(MAX_ITEMS+1)-1:0] next_item,
    output logic [$clog2(MAX_ITEMS+1)-1:0] prev_item,
    output logic [$clog2(MAX_ITEMS+1)-1:0] in_count,
    output logic [$clog2(MAX_ITEMS+1)-1:0] out_count,
    output logic [$clog2(MAX_ITEMS+1)-1:0] first_in,
    output logic [$clog2(MAX_ITEMS+1)-1:0] last_in,
    output logic [$clog2(MAX_ITEMS+1)-1:0] first_out,
    output logic [$clog2(MAX_ITEMS+1)-1:0] last_out
);

`include "assert_macros.svh"

    localparam int IW    = $clog2(MAX_ITEMS + 1);
    localparam int DEPTH = MAX_ITEMS + 1;

    res_stat_t      res_stat;
    ram_ctl_t       ram_ctl;
    logic           res_ready;
    logic [IW-1:0]  res_next, res_prev;
    logic [IW-1:0]  list_in_count, list_out_count;
    logic [IW-1:0]  list_first_in, list_last_in, list_first_out, list_last_out;
    logic [IW-1:0]  raddr, waddr_next, waddr_prev, wdata_prev, rdata_prev;
    logic [IW:0]    wdata_next, rdata_next;

    logic           out_valid_reg;
    logic           index_ok_reg, in_set_reg;
    logic [IW-1:0]  next_item_reg, prev_item_reg, in_count_reg, out_count_reg;
    logic [IW-1:0]  first_in_reg, last_in_reg, first_out_reg, last_out_reg;
    logic           load;

    tlip_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .size_in_use    (size_in_use),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .item_index     (item_index),
        .res_ready      (res_ready),
        .res_stat       (res_stat),
        .res_next       (res_next),
        .res_prev       (res_prev),
        .list_in_count  (list_in_count),
        .list_out_count (list_out_count),
        .list_first_in  (list_first_in),
        .list_last_in   (list_last_in),
        .list_first_out (list_first_out),
        .list_last_out  (list_last_out),
        .ram_ctl        (ram_ctl),
        .raddr          (raddr),
        .waddr_next     (waddr_next),
        .wdata_next     (wdata_next),
        .waddr_prev     (waddr_prev),
        .wdata_prev     (wdata_prev),
        .rdata_next     (rdata_next),
        .rdata_prev     (rdata_prev)
    );

    // forward links with the in-list flag on top
    tlip_ram #(
        .WIDTH (IW + 1),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .clk   (clk),
        .we    (ram_ctl.next_we),
        .waddr (waddr_next),
        .wdata (wdata_next),
        .re    (ram_ctl.rd_en),
        .raddr (raddr),
        .rdata (rdata_next)
    );

    tlip_ram #(
        .WIDTH (IW),
        .DEPTH (DEPTH)
    ) u_prev_ram (
        .clk   (clk),
        .we    (ram_ctl.prev_we),
        .waddr (waddr_prev),
        .wdata (wdata_prev),
        .re    (ram_ctl.rd_en),
        .raddr (raddr),
        .rdata (rdata_prev)
    );

    assign res_ready = !out_valid_reg || out_ready;
    assign load      = res_stat.valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_ok_reg  <= res_stat.ok;
            in_set_reg    <= res_stat.in_set;
            next_item_reg <= res_next;
            prev_item_reg <= res_prev;
            in_count_reg  <= list_in_count;
            out_count_reg <= list_out_count;
            first_in_reg  <= list_first_in;
            last_in_reg   <= list_last_in;
            first_out_reg <= list_first_out;
            last_out_reg  <= list_last_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign index_ok  = index_ok_reg;
    assign in_set    = in_set_reg;
    assign next_item = next_item_reg;
    assign prev_item = prev_item_reg;
    assign in_count  = in_count_reg;
    assign out_count = out_count_reg;
    assign first_in  = first_in_reg;
    assign last_in   = last_in_reg;
    assign first_out = first_out_reg;
    assign last_out  = last_out_reg;

    `ASSERT_IMPL(a_in_empty, in_ready && (list_first_in == '0), list_in_count == '0)
    `ASSERT_IMPL(a_out_empty, in_ready && (list_first_out == '0), list_out_count == '0)
    `ASSERT_NEXT(a_cfg_init, cfg_we, !in_ready)
    `ASSERT_NEXT(a_res_hold, res_stat.valid && !res_ready, res_stat.valid)

endmodule

@@ tb/sv/tb_two_list_index_partition_unit.sv @@
// Self-checking testbench for the two-list index partition unit.
module tb_two_list_index_partition_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import tlip_pkg::*;

    localparam int MAXN = TLIP_MAX_ITEMS;
    localparam int W = $clog2(MAXN + 1);
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]   op;
        logic [W-1:0] idx;
    } part_req_t;

    typedef struct packed {
        logic         ok;
        logic         inset;
        logic [W-1:0] nxt;
        logic [W-1:0] prv;
        logic [W-1:0] inc;
        logic [W-1:0] outc;
        logic [W-1:0] fi;
        logic [W-1:0] li;
        logic [W-1:0] fo;
        logic [W-1:0] lo;
    } part_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [W-1:0] size_in_use = '0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    logic [1:0]   op = '0;
    logic [W-1:0] item_index = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic         index_ok;
    logic         in_set;
    logic [W-1:0] next_item;
    logic [W-1:0] prev_item;
    logic [W-1:0] in_count;
    logic [W-1:0] out_count;
    logic [W-1:0] first_in;
    logic [W-1:0] last_in;
    logic [W-1:0] first_out;
    logic [W-1:0] last_out;

    two_list_index_partition_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .size_in_use(size_in_use),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .item_index (item_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .index_ok   (index_ok),
        .in_set     (in_set),
        .next_item  (next_item),
        .prev_item  (prev_item),
        .in_count   (in_count),
        .out_count  (out_count),
        .first_in   (first_in),
        .last_in    (last_in),
        .first_out  (first_out),
        .last_out   (last_out)
    );

    // Partition state as predicted; out-list links are held negated
    logic signed [W:0] fwd_link [0:MAXN];
    logic signed [W:0] bwd_link [0:MAXN];
    logic [W-1:0] in_first, in_last, out_first, out_last, in_num, out_num, part_size;

    part_req_t    request_queue[$];
    part_result_t predicted_reports[$];

    int  errors = 0;
    int  cycles = 0;
    int  src_gap_pct = 0;
    int  sink_gap_pct = 0;
    int  src_gap_left = 0;
    int  sink_stall_left = 0;
    bit  req_taken = 1'b0;
    bit  long_hold_go = 1'b0;
    bit  long_hold_done = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [W-1:0] link_target(logic signed [W:0] v);
        logic [W:0] mag;
        mag = (v < 0) ? -v : v;
        return (mag > MAXN) ? '0 : mag[W-1:0];
    endfunction

    function automatic bit in_member(logic [W-1:0] i);
        return fwd_link[i] > 0 || i == in_last;
    endfunction

    function automatic void rebuild_lists(logic [W-1:0] v);
        int k;
        if (v == 0)
            part_size = 1;
        else if (v > MAXN)
            part_size = MAXN;
        else
            part_size = v;
        for (k = 0; k <= MAXN; k++)
        begin
            fwd_link[k] = '0;
            bwd_link[k] = '0;
        end
        for (k = 1; k < part_size; k++)
        begin
            fwd_link[k] = -(W+1)'(k + 1);
            bwd_link[k + 1] = -(W+1)'(k);
        end
        in_first = '0;
        in_last = '0;
        out_first = 1;
        out_last = part_size;
        in_num = '0;
        out_num = part_size;
    endfunction

    // Unlink i from its list and append it to the tail of the other one
    function automatic void move_index(logic [W-1:0] i);
        logic [W-1:0] nx;
        logic [W-1:0] pv;
        nx = link_target(fwd_link[i]);
        pv = link_target(bwd_link[i]);
        if (in_member(i))
        begin
            if (nx == 0) in_last = pv; else bwd_link[nx] = {1'b0, pv};
            if (pv == 0) in_first = nx; else fwd_link[pv] = {1'b0, nx};
            fwd_link[i] = '0;
            if (out_last == 0)
            begin
                out_first = i;
                bwd_link[i] = '0;
            end
            else
            begin
                fwd_link[out_last] = -{1'b0, i};
                bwd_link[i] = -{1'b0, out_last};
            end
            out_last = i;
            in_num = in_num - 1;
            out_num = out_num + 1;
        end
        else
        begin
            if (nx == 0) out_last = pv; else bwd_link[nx] = -{1'b0, pv};
            if (pv == 0) out_first = nx; else fwd_link[pv] = -{1'b0, nx};
            fwd_link[i] = '0;
            if (in_last == 0)
            begin
                in_first = i;
                bwd_link[i] = '0;
            end
            else
            begin
                fwd_link[in_last] = {1'b0, i};
                bwd_link[i] = {1'b0, in_last};
            end
            in_last = i;
            in_num = in_num + 1;
            out_num = out_num - 1;
        end
    endfunction

    function automatic part_result_t update_partition(logic [1:0] code, logic [W-1:0] idx);
        part_result_t r;
        int guard;
        r = '0;
        if (code == OP_CLEAR)
        begin
            guard = 0;
            while (in_first != 0 && guard <= MAXN)
            begin
                move_index(in_first);
                guard++;
            end
            r.ok = 1'b1;
        end
        else if ((code == OP_SWAP || code == OP_READ) && idx >= 1 && idx <= part_size)
        begin
            if (code == OP_SWAP)
                move_index(idx);
            r.ok = 1'b1;
            r.inset = in_member(idx);
            r.nxt = link_target(fwd_link[idx]);
            r.prv = link_target(bwd_link[idx]);
        end
        r.inc = in_num;
        r.outc = out_num;
        r.fi = in_first;
        r.li = in_last;
        r.fo = out_first;
        r.lo = out_last;
        return r;
    endfunction

    function automatic part_req_t random_request();
        part_req_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            r.op = OP_SWAP;
        else if (pick < 82)
            r.op = OP_READ;
        else if (pick < 94)
            r.op = OP_CLEAR;
        else
            r.op = OP_UNUSED;
        if ($urandom_range(99) < 7)
            r.idx = $urandom_range(1) ? '0 : W'($urandom_range(511, part_size + 1));
        else
            r.idx = W'($urandom_range(part_size, 1));
        return r;
    endfunction

    task automatic check_field(string name, logic [W-1:0] exp_v, logic [W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic queue_req(logic [1:0] code, logic [W-1:0] idx);
        part_req_t r;
        r.op = code;
        r.idx = idx;
        request_queue.push_back(r);
    endtask

    task automatic fill_random(int n);
        repeat (n) request_queue.push_back(random_request());
    endtask

    // Waits until every request has been taken and answered
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end while (request_queue.size() != 0 || in_valid || predicted_reports.size() != 0);
    endtask

    task automatic write_size(logic [W-1:0] v);
        wait_drained();
        repeat (8) @(posedge clk);
        @(negedge clk);
        size_in_use <= v;
        cfg_we <= 1'b1;
        rebuild_lists(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        #1;
    endtask

    // Request driver
    always @(negedge clk)
    begin : drive_requests
        part_req_t nreq;
        if (!in_valid || req_taken)
        begin
            if (src_gap_left > 0)
            begin
                src_gap_left = src_gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                nreq = request_queue.pop_front();
                op <= nreq.op;
                item_index <= nreq.idx;
                in_valid <= 1'b1;
                if ($urandom_range(99) < src_gap_pct)
                    src_gap_left = $urandom_range(12, 1);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result sink with random stall bursts and one long hold-off
    always @(negedge clk)
    begin
        if (long_hold_go && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            sink_stall_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (sink_stall_left > 0)
        begin
            sink_stall_left = sink_stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(99) < sink_gap_pct)
        begin
            sink_stall_left = $urandom_range(11, 0);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare accepted results, then predict for a newly taken request
    always @(posedge clk)
    begin : score
        part_result_t exp_r;
        req_taken <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_reports.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding", $time);
            end
            else
            begin
                exp_r = predicted_reports.pop_front();
                check_field("index_ok", exp_r.ok, index_ok);
                check_field("in_set", exp_r.inset, in_set);
                check_field("next_item", exp_r.nxt, next_item);
                check_field("prev_item", exp_r.prv, prev_item);
                check_field("in_count", exp_r.inc, in_count);
                check_field("out_count", exp_r.outc, out_count);
                check_field("first_in", exp_r.fi, first_in);
                check_field("last_in", exp_r.li, last_in);
                check_field("first_out", exp_r.fo, first_out);
                check_field("last_out", exp_r.lo, last_out);
            end
        end
        if (rst_n && in_valid && in_ready)
            predicted_reports.push_back(update_partition(op, item_index));
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        rebuild_lists(W'(TLIP_SIZE_DEFAULT));
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // Full default size: range edges, head/middle/tail moves, clears
        src_gap_pct = 20;
        sink_gap_pct = 20;
        queue_req(OP_READ, 1);
        queue_req(OP_READ, 256);
        queue_req(OP_READ, 0);
        queue_req(OP_READ, 257);
        queue_req(OP_READ, 511);
        queue_req(OP_SWAP, 1);
        queue_req(OP_SWAP, 256);
        queue_req(OP_SWAP, 128);
        queue_req(OP_READ, 128);
        queue_req(OP_SWAP, 256);
        queue_req(OP_SWAP, 1);
        queue_req(OP_UNUSED, 5);
        queue_req(OP_CLEAR, 9);
        queue_req(OP_CLEAR, 0);
        queue_req(OP_SWAP, 0);
        queue_req(OP_SWAP, 300);
        queue_req(OP_SWAP, 2);
        queue_req(OP_SWAP, 3);
        queue_req(OP_SWAP, 4);
        queue_req(OP_READ, 3);
        queue_req(OP_SWAP, 3);
        queue_req(OP_CLEAR, 511);
        queue_req(OP_READ, 2);

        // Size 0 is taken as one index: out-list can run empty
        write_size(0);
        queue_req(OP_SWAP, 1);
        queue_req(OP_READ, 1);
        queue_req(OP_SWAP, 2);
        queue_req(OP_SWAP, 1);
        queue_req(OP_SWAP, 1);
        queue_req(OP_CLEAR, 1);
        fill_random(15);

        // Oversized write clamps to the maximum
        write_size(511);
        src_gap_pct = 0;
        sink_gap_pct = 0;
        fill_random(80);

        write_size(2);
        src_gap_pct = 30;
        sink_gap_pct = 30;
        fill_random(60);

        // Sink holds off while requests keep coming
        write_size(17);
        src_gap_pct = 0;
        sink_gap_pct = 10;
        fill_random(150);
        @(posedge clk);
        long_hold_go = 1'b1;

        write_size(256);
        src_gap_pct = 25;
        sink_gap_pct = 25;
        fill_random(90);

        write_size(5);
        fill_random(80);

        write_size(1);
        fill_random(20);

        // Last stretch at full rate
        write_size(40);
        src_gap_pct = 0;
        sink_gap_pct = 0;
        fill_random(120);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/tlip_pkg.sv
design/tlip_ram.sv
design/tlip_ctrl.sv
design/tlip_top_dummy.sv
design/two_list_index_partition_unit.sv
tb/sv/tb_two_list_index_partition_unit.sv
